@@ rtl/core/pcmdd_pkg.sv @@
`timescale 1ns / 1ps

package pcmdd_pkg;

    localparam int MAX_CHANNELS_DEF = 16;

    localparam int BYTE_W     = 8;
    localparam int SAMPLE_W   = 32;
    localparam int INDEX_W    = 32;
    localparam int FMT_W      = 3;
    localparam int CHANS_W    = 5;
    localparam int LIMIT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // sample format codes
    localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_S16 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_S24 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_S32 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_F32 = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd2;

    typedef struct packed {
        logic [FMT_W-1:0]   fmt;
        logic [CHANS_W-1:0] chans;
        logic [LIMIT_W-1:0] limit;
    } pcmdd_cfg_t;

    typedef struct packed {
        logic clear;
        logic take_byte;
        logic load_raw;
        logic decode;
        logic accum;
        logic div_load;
        logic div_step;
        logic put;
    } pcmdd_cmd_t;

    typedef struct packed {
        logic restart;
        logic blocked;
        logic byte_final;
        logic chan_last;
        logic div_last;
        logic out_free;
    } pcmdd_status_t;

endpackage

@@ rtl/core/pcmdd_ctrl.sv @@
`timescale 1ns / 1ps

module pcmdd_ctrl import pcmdd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  pcmdd_status_t status,
    output pcmdd_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_ACC,
        ST_DIVL,
        ST_DIV,
        ST_PUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (status.restart) begin
                        cmd.clear = 1'b1;
                    end else if (!status.blocked) begin
                        if (status.byte_final) begin
                            cmd.load_raw = 1'b1;
                            state_next   = ST_DEC;
                        end else begin
                            cmd.take_byte = 1'b1;
                        end
                    end
                end
            end
            ST_DEC: begin
                cmd.decode = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.accum  = 1'b1;
                state_next = status.chan_last ? ST_DIVL : ST_IDLE;
            end
            ST_DIVL: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (status.out_free) begin
                    cmd.put    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/pcmdd_datapath.sv @@
`timescale 1ns / 1ps

module pcmdd_datapath import pcmdd_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pcmdd_cfg_t                  cfg,
    input  pcmdd_cmd_t                  cmd,
    output pcmdd_status_t               status,
    input  logic [BYTE_W-1:0]           s_tdata,
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [SAMPLE_W+INDEX_W-1:0] m_tdata,
    output logic                        m_tlast
);

    localparam int SUM_W = SAMPLE_W + $clog2(MAX_CHANNELS);
    localparam int CHP_W = (MAX_CHANNELS > 16) ? CHANS_W :
                           ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1);
    localparam int CNT_W = $clog2(SUM_W);

    // progress
    logic [1:0]                  pos_reg, pos_next;
    logic [23:0]                 partial_reg, partial_next;
    logic [CHP_W-1:0]            ch_pos_reg, ch_pos_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic [INDEX_W-1:0]          frame_count_reg, frame_count_next;
    logic                        finished_reg, finished_next;
    // sample pipeline
    logic [SAMPLE_W-1:0]         raw_reg, raw_next;
    logic signed [SAMPLE_W-1:0]  sample_reg, sample_next;
    // divider
    logic [CHANS_W-1:0]          rem_reg, rem_next;
    logic [SUM_W-1:0]            quot_reg, quot_next;
    logic                        neg_reg, neg_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    // output stage
    logic                        out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]         out_sample_reg, out_sample_next;
    logic [INDEX_W-1:0]          out_index_reg, out_index_next;
    logic                        out_last_reg, out_last_next;

    logic [FMT_W-1:0]            fmt_code;
    logic [1:0]                  bytes_m1;
    logic [CHANS_W-1:0]          active;
    logic [SAMPLE_W-1:0]         byte_sh;
    logic [SUM_W-1:0]            sum_abs;
    logic [CHANS_W+1:0]          trial;
    logic [INDEX_W-1:0]          fc_inc;

    // float32 conversion
    logic [7:0]                  fl_exp;
    logic [23:0]                 fl_man;
    logic [2:0]                  fl_lsh;
    logic [4:0]                  fl_rsh;
    logic [23:0]                 fl_t;
    logic [30:0]                 fl_mag;
    logic [SAMPLE_W-1:0]         fl_val;
    logic [7:0]                  u8_ofs;

    assign fmt_code = (cfg.fmt > FMT_F32) ? FMT_S16 : cfg.fmt;

    always_comb begin
        case (fmt_code)
            FMT_U8:  bytes_m1 = 2'd0;
            FMT_S16: bytes_m1 = 2'd1;
            FMT_S24: bytes_m1 = 2'd2;
            default: bytes_m1 = 2'd3;
        endcase
    end

    always_comb begin
        if (cfg.chans == '0) begin
            active = CHANS_W'(1);
        end else if (32'(cfg.chans) > 32'(MAX_CHANNELS)) begin
            active = CHANS_W'(MAX_CHANNELS);
        end else begin
            active = cfg.chans;
        end
    end

    assign status.restart    = s_tuser;
    assign status.blocked    = finished_reg || (frame_count_reg >= cfg.limit);
    assign status.byte_final = (pos_reg >= bytes_m1);
    assign status.chan_last  = ((6'(ch_pos_reg) + 6'd1) >= {1'b0, active});
    assign status.div_last   = (cnt_reg == '0);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign byte_sh = SAMPLE_W'(s_tdata) << {pos_reg, 3'b000};

    // IEEE single to Q1.30, round half away from zero
    always_comb begin
        fl_exp = raw_reg[30:23];
        fl_man = {1'b1, raw_reg[22:0]};
        fl_lsh = 3'(fl_exp - 8'd120);
        fl_rsh = 5'(8'd119 - fl_exp);
        fl_t   = fl_man >> fl_rsh;
        if (fl_exp == 8'hFF || fl_exp == 8'h00) begin
            fl_mag = '0;
        end else if (fl_exp >= 8'd127) begin
            fl_mag = 31'h4000_0000;
        end else if (fl_exp >= 8'd120) begin
            fl_mag = 31'(31'(fl_man) << fl_lsh);
        end else if (fl_exp >= 8'd96) begin
            fl_mag = 31'((25'(fl_t) + 25'd1) >> 1);
        end else begin
            fl_mag = '0;
        end
        fl_val = raw_reg[31] ? (SAMPLE_W'(0) - {1'b0, fl_mag}) : {1'b0, fl_mag};
    end

    assign u8_ofs = raw_reg[7:0] ^ 8'h80;

    always_comb begin
        case (fmt_code)
            FMT_U8:  sample_next = {u8_ofs[7], u8_ofs, 23'd0};
            FMT_S16: sample_next = {raw_reg[15], raw_reg[15:0], 15'd0};
            FMT_S24: sample_next = {raw_reg[23], raw_reg[23:0], 7'd0};
            FMT_S32: sample_next = {raw_reg[31], raw_reg[31:1]};
            default: sample_next = fl_val;
        endcase
    end

    assign sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign trial   = {1'b0, rem_reg, quot_reg[SUM_W-1]} - {2'b00, active};
    assign fc_inc  = frame_count_reg + INDEX_W'(1);

    always_comb begin
        pos_next         = pos_reg;
        partial_next     = partial_reg;
        ch_pos_next      = ch_pos_reg;
        sum_next         = sum_reg;
        frame_count_next = frame_count_reg;
        finished_next    = finished_reg;
        raw_next         = raw_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        neg_next         = neg_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_sample_next  = out_sample_reg;
        out_index_next   = out_index_reg;
        out_last_next    = out_last_reg;

        if (cmd.clear) begin
            pos_next         = '0;
            partial_next     = '0;
            ch_pos_next      = '0;
            sum_next         = '0;
            frame_count_next = '0;
            finished_next    = 1'b0;
        end
        if (cmd.take_byte) begin
            partial_next = partial_reg | byte_sh[23:0];
            pos_next     = pos_reg + 2'd1;
        end
        if (cmd.load_raw) begin
            raw_next     = {8'd0, partial_reg} | byte_sh;
            pos_next     = '0;
            partial_next = '0;
        end
        if (cmd.accum) begin
            sum_next = sum_reg + SUM_W'(sample_reg);
            if (!status.chan_last) begin
                ch_pos_next = ch_pos_reg + CHP_W'(1);
            end
        end
        if (cmd.div_load) begin
            quot_next   = sum_abs;
            neg_next    = sum_reg[SUM_W-1];
            rem_next    = '0;
            cnt_next    = CNT_W'(SUM_W - 1);
            sum_next    = '0;
            ch_pos_next = '0;
        end
        if (cmd.div_step) begin
            if (!trial[CHANS_W+1]) begin
                rem_next = trial[CHANS_W-1:0];
            end else begin
                rem_next = {rem_reg[CHANS_W-2:0], quot_reg[SUM_W-1]};
            end
            quot_next = {quot_reg[SUM_W-2:0], !trial[CHANS_W+1]};
            cnt_next  = cnt_reg - CNT_W'(1);
        end
        if (cmd.put) begin
            out_valid_next   = 1'b1;
            out_sample_next  = neg_reg ? (SAMPLE_W'(0) - quot_reg[SAMPLE_W-1:0])
                                       : quot_reg[SAMPLE_W-1:0];
            out_index_next   = frame_count_reg;
            out_last_next    = (fc_inc >= cfg.limit);
            frame_count_next = fc_inc;
            if (fc_inc >= cfg.limit) begin
                finished_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            partial_reg     <= '0;
            ch_pos_reg      <= '0;
            sum_reg         <= '0;
            frame_count_reg <= '0;
            finished_reg    <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            partial_reg     <= partial_next;
            ch_pos_reg      <= ch_pos_next;
            sum_reg         <= sum_next;
            frame_count_reg <= frame_count_next;
            finished_reg    <= finished_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg <= raw_next;
        if (cmd.decode) begin
            sample_reg <= sample_next;
        end
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        neg_reg        <= neg_next;
        out_sample_reg <= out_sample_next;
        out_index_reg  <= out_index_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_index_reg, out_sample_reg};
    assign m_tlast  = out_last_reg;

    // a waiting result is never overwritten
    a_put_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.put |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    a_put_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.put |=> out_valid_reg)
        else $error("result not presented after put");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (frame_count_reg == '0 && !finished_reg && pos_reg == '0))
        else $error("restart left progress behind");

    a_finished_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (finished_reg && !cmd.clear) |=> finished_reg)
        else $error("finished flag dropped without restart");

endmodule

@@ rtl/core/pcm_sample_decode_downmix.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata: data_byte[7:0]; s_tuser: restart
// m_        out  m_tvalid/m_tready    m_tdata: mono_sample[31:0], frame_index[63:32];
//                                     m_tlast: last_frame
// cfg_      in   cfg_valid/cfg_ready  cfg_index (0 format, 1 channels, 2 frame limit),
//                                     cfg_data
//
// A byte that does not complete a sample is only stored. A byte that completes a
// sample is assembled, converted and accumulated in turn; no new byte is taken
// meanwhile. Frame completion adds divider load, division and put: the channel
// average comes from a restoring divider that resolves one quotient bit per cycle.
// Reset is synchronous and clears progress and the result register; the
// configuration returns to signed 16-bit, one channel, frame limit 0.
// One result register sits on the output; bytes keep being accepted while it
// waits, and a finished frame holds in the controller until that register frees.

module pcm_sample_decode_downmix import pcmdd_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input beats
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [BYTE_W-1:0]           s_tdata,   // data_byte[7:0]
    input  logic                        s_tuser,   // restart
    // result beats
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [SAMPLE_W+INDEX_W-1:0] m_tdata,   // mono_sample[31:0], frame_index[63:32]
    output logic                        m_tlast,   // last_frame
    // register writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    pcmdd_cfg_t    cfg_reg;
    pcmdd_cfg_t    cfg_next;
    pcmdd_cmd_t    cmd;
    pcmdd_status_t status;

    // register file: always ready, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FORMAT:   cfg_next.fmt   = cfg_data[FMT_W-1:0];
                REG_CHANNELS: cfg_next.chans = cfg_data[CHANS_W-1:0];
                REG_LIMIT:    cfg_next.limit = cfg_data[LIMIT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fmt   <= FMT_S16;
            cfg_reg.chans <= CHANS_W'(1);
            cfg_reg.limit <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencing of byte capture, conversion, accumulation and division
    pcmdd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // sample assembly, format conversion, channel sum, divider, result register
    pcmdd_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
